// ===== src/generational_handle_pool_macros.svh =====
// ----------------------------------------------------------------------------
// Generational handle pool assertion macros
// Shorthand for the clocked, reset-qualified checks used in the pool RTL.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_POOL_MACROS_SVH
`define GENERATIONAL_HANDLE_POOL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ghp_pkg.sv =====
// ----------------------------------------------------------------------------
// Generational handle pool package
// Port widths, operation codes and the words passed between the pool's parts.
// ----------------------------------------------------------------------------
package ghp_pkg;

  // Widths of the external fields.
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IDX_PORT_W  = 6;
  localparam int unsigned GEN_PORT_W  = 16;
  localparam int unsigned LIVE_PORT_W = 7;
  localparam int unsigned CFG_W       = 7;

  // Capacity register value after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Default build parameters.
  localparam int unsigned DEF_POOL_SLOTS = 64;
  localparam int unsigned DEF_GEN_BITS   = 16;

  // Depth of the command and result queues.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_e                   op;
    logic [IDX_PORT_W-1:0] idx;
    logic [GEN_PORT_W-1:0] hgen;
    logic                  oor;
  } cmd_t;

  // Result word.
  typedef struct packed {
    logic                   ok;
    logic [IDX_PORT_W-1:0]  idx;
    logic [GEN_PORT_W-1:0]  gen;
    logic [LIVE_PORT_W-1:0] live;
  } res_t;

endpackage

// ===== src/ghp_fifo.sv =====
// ----------------------------------------------------------------------------
// Generational handle pool queue
// Small first-in first-out buffer built from registers.
// ----------------------------------------------------------------------------
module ghp_fifo import ghp_pkg::*; #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  // Handshake qualification.
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Storage needs no reset: an entry is only read once written.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/ghp_front.sv =====
// ----------------------------------------------------------------------------
// Generational handle pool front end
// Holds the capacity register, classifies incoming words and queues them.
// ----------------------------------------------------------------------------
module ghp_front import ghp_pkg::*; #(
  parameter int unsigned POOL_SLOTS = DEF_POOL_SLOTS,
  localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [IDX_PORT_W-1:0] slot_index_i,
  input  logic [GEN_PORT_W-1:0] handle_generation_i,
  output logic [CNT_W-1:0]      cap_o,
  output logic                  cmd_valid_o,
  output cmd_t                  cmd_o,
  input  logic                  cmd_pop_i
);

  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] cfg_q;
  logic [CMP_W-1:0] cfg_ext, cap_ext;
  cmd_t             cmd_in;
  logic             cmd_empty;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Active capacity saturates at the built pool size.
  assign cfg_ext = CMP_W'(cfg_q);
  assign cap_ext = (cfg_ext > CMP_W'(POOL_SLOTS)) ? CMP_W'(POOL_SLOTS) : cfg_ext;
  assign cap_o   = CNT_W'(cap_ext);

  // Classify the incoming word, flagging an index beyond the capacity.
  always_comb begin
    cmd_in.op   = op_e'(opcode_i);
    cmd_in.idx  = slot_index_i;
    cmd_in.hgen = handle_generation_i;
    cmd_in.oor  = (CMP_W'(slot_index_i) >= cap_ext);
  end

  // Command queue towards the back end.
  ghp_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

// ===== src/ghp_back.sv =====
// ----------------------------------------------------------------------------
// Generational handle pool back end
// Searches the reserved bitmap, updates the generation memory and the counts.
// ----------------------------------------------------------------------------
`include "generational_handle_pool_macros.svh"

module ghp_back import ghp_pkg::*; #(
  parameter int unsigned POOL_SLOTS = DEF_POOL_SLOTS,
  parameter int unsigned GEN_BITS   = DEF_GEN_BITS,
  localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] cap_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output res_t             res_o
);

  localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_DONE
  } state_e;

  state_e                state_q;
  cmd_t                  cmd_q;
  logic                  found_q;
  logic [IDX_W-1:0]      tgt_q;
  logic [POOL_SLOTS-1:0] rsv_q, rsv_d;
  logic [POOL_SLOTS-1:0] gen_vld_q;
  logic [CNT_W-1:0]      live_q, live_d;
  logic [CNT_W-1:0]      hint_q, hint_d;
  logic                  rd_vld_q;
  logic [GEN_BITS-1:0]   rd_q;
  logic [GEN_BITS-1:0]   gen_mem [POOL_SLOTS];

  logic [POOL_SLOTS-1:0] cand, first;
  logic [IDX_W-1:0]      find_idx, rd_addr;
  logic                  find_ok, issue, mem_we;
  logic [GEN_BITS-1:0]   gen_cur, gen_inc;

  // Free slots at or above the hint and below the capacity.
  always_comb begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      cand[i] = !rsv_q[i] && (CNT_W'(i) >= hint_q) && (CNT_W'(i) < cap_i);
    end
  end

  // Isolate the lowest candidate and encode its position.
  assign first   = cand & (~cand + POOL_SLOTS'(1));
  assign find_ok = |cand;

  always_comb begin
    find_idx = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if (first[i]) begin
        find_idx = find_idx | IDX_W'(i);
      end
    end
  end

  // A command starts only when the result queue has room for its word.
  assign issue     = cmd_valid_i && !res_full_i;
  assign cmd_pop_o = (state_q == ST_IDLE) && issue;
  assign rd_addr   = (cmd_i.op == OP_ALLOC) ? find_idx : IDX_W'(cmd_i.idx);

  // Never-written generations read as zero.
  assign gen_cur = rd_vld_q ? rd_q : '0;
  assign gen_inc = gen_cur + GEN_BITS'(1);

  // Outcome of the latched command, applied in the done state.
  always_comb begin
    rsv_d     = rsv_q;
    live_d    = live_q;
    hint_d    = hint_q;
    mem_we    = 1'b0;
    res_o.ok  = 1'b0;
    res_o.idx = '0;
    res_o.gen = '0;
    unique case (cmd_q.op)
      OP_ALLOC: begin
        if (found_q) begin
          rsv_d[tgt_q] = 1'b1;
          live_d       = live_q + CNT_W'(1);
          hint_d       = CNT_W'(tgt_q) + CNT_W'(1);
          mem_we       = (state_q == ST_DONE);
          res_o.ok     = 1'b1;
          res_o.idx    = IDX_PORT_W'(tgt_q);
          res_o.gen    = GEN_PORT_W'(gen_inc);
        end
      end
      OP_CLEAR: begin
        rsv_d    = '0;
        live_d   = '0;
        hint_d   = '0;
        res_o.ok = 1'b1;
      end
      OP_FREE: begin
        res_o.idx = cmd_q.idx;
        if (!cmd_q.oor) begin
          res_o.gen = GEN_PORT_W'(gen_cur);
          if (rsv_q[tgt_q]) begin
            res_o.ok     = 1'b1;
            rsv_d[tgt_q] = 1'b0;
            if (live_q != '0) begin
              live_d = live_q - CNT_W'(1);
            end
            if (CNT_W'(tgt_q) < hint_q) begin
              hint_d = CNT_W'(tgt_q);
            end
          end
        end
      end
      OP_CHECK: begin
        res_o.idx = cmd_q.idx;
        if (!cmd_q.oor) begin
          res_o.gen = GEN_PORT_W'(gen_cur);
          res_o.ok  = rsv_q[tgt_q] && (gen_cur == GEN_BITS'(cmd_q.hgen));
        end
      end
      default: begin
        res_o.ok = 1'b0;
      end
    endcase
    res_o.live = LIVE_PORT_W'(live_d);
  end

  assign res_push_o = (state_q == ST_DONE);

  // Sequencer with the bitmap, counts and generation valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= '0;
      found_q   <= 1'b0;
      tgt_q     <= '0;
      rsv_q     <= '0;
      gen_vld_q <= '0;
      live_q    <= '0;
      hint_q    <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (issue) begin
            cmd_q    <= cmd_i;
            found_q  <= find_ok;
            tgt_q    <= rd_addr;
            rd_vld_q <= gen_vld_q[rd_addr];
            state_q  <= ST_DONE;
          end
        end
        ST_DONE: begin
          rsv_q  <= rsv_d;
          live_q <= live_d;
          hint_q <= hint_d;
          if (mem_we) begin
            gen_vld_q[tgt_q] <= 1'b1;
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Generation memory: read on issue, written back on a successful allocate.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      rd_q <= gen_mem[rd_addr];
    end
    if (mem_we) begin
      gen_mem[tgt_q] <= gen_inc;
    end
  end

  // The live count always equals the number of reserved slots.
  `GHP_ASSERT_NOW(a_live_tally, 1'b1, live_q == CNT_W'($countones(rsv_q)), "live count mismatch")
  // A result word is only produced when the queue can take it.
  `GHP_ASSERT_NOW(a_res_room, res_push_o, !res_full_i, "result pushed into full queue")
  // A clear leaves every slot free.
  `GHP_ASSERT_NEXT(a_clear_all, res_push_o && (cmd_q.op == OP_CLEAR), rsv_q == '0, "clear missed")
  // A successful allocate leaves its slot reserved.
  `GHP_ASSERT_NEXT(a_alloc_set, res_push_o && (cmd_q.op == OP_ALLOC) && found_q, rsv_q[tgt_q],
                   "allocated slot not reserved")

endmodule

// ===== src/generational_handle_pool.sv =====
// ----------------------------------------------------------------------------
// Generational handle pool
// Allocates, frees, checks and clears generation-tagged slot handles.
// ----------------------------------------------------------------------------
// Commands enter through a queue-style port: a word is taken when push is
// high and full is low. It carries an opcode (allocate, free, check, clear),
// a slot index and the handle's generation. Every command yields exactly one
// result word, presented while empty is low and removed when pop is high.
// The user must see that the capacity register (cfg_we_i, cfg_wdata_i) is
// written only while idle; the block itself does not enforce this. For each
// command the execution unit first searches the reserved bitmap and reads
// the generation memory, then writes back and produces the result; it takes
// a new command only once the last one has produced its result.
// A two-word command queue and a two-word result queue decouple the sides;
// when the receiver stops popping, execution halts once the result queue
// fills and full rises once the command queue fills. Nothing is dropped.
// Reset frees every slot, zeroes all generations and counts and sets the
// capacity to 64; no clearing pass is needed, the block is ready at once.
// ----------------------------------------------------------------------------
module generational_handle_pool import ghp_pkg::*; #(
  parameter int unsigned POOL_SLOTS = DEF_POOL_SLOTS,
  parameter int unsigned GEN_BITS   = DEF_GEN_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   push,
  output logic                   full,
  input  logic [OP_W-1:0]        opcode_i,
  input  logic [IDX_PORT_W-1:0]  slot_index_i,
  input  logic [GEN_PORT_W-1:0]  handle_generation_i,
  output logic                   empty,
  input  logic                   pop,
  output logic                   ok_o,
  output logic [IDX_PORT_W-1:0]  result_index_o,
  output logic [GEN_PORT_W-1:0]  result_generation_o,
  output logic [LIVE_PORT_W-1:0] live_slots_o
);

  localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);

  logic [CNT_W-1:0] cap;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  logic             res_full, res_push;
  res_t             res_in, res_out;

  // Front end: capacity register, classification and command queue.
  ghp_front #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .push_i              (push),
    .full_o              (full),
    .opcode_i            (opcode_i),
    .slot_index_i        (slot_index_i),
    .handle_generation_i (handle_generation_i),
    .cap_o               (cap),
    .cmd_valid_o         (cmd_valid),
    .cmd_o               (cmd),
    .cmd_pop_i           (cmd_pop)
  );

  // Back end: bitmap search and generation update.
  ghp_back #(
    .POOL_SLOTS (POOL_SLOTS),
    .GEN_BITS   (GEN_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue towards the receiver.
  ghp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign ok_o                = res_out.ok;
  assign result_index_o      = res_out.idx;
  assign result_generation_o = res_out.gen;
  assign live_slots_o        = res_out.live;

endmodule
